// File: rtl/hefp_pkg.sv
// ----------------------------------------------------------------------------
// hefp_pkg
// Shared types and constants for the heading/elevation CORDIC pipeline.
// ----------------------------------------------------------------------------
package hefp_pkg;

  // datapath widths
  localparam int unsigned XW        = 64;
  localparam int unsigned ZW        = 34;
  localparam int unsigned YAW_W     = 17;
  localparam int unsigned PITCH_W   = 15;
  localparam int unsigned TABLE_LEN = 32;

  // inverse cordic gain in q32
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // binary angle of half a turn, 2^32 units per turn
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'h8000_0000);

  // atan(2^-i) in binary angle units
  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // direction flags of the difference vector
  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dz_zero;
    logic dz_neg;
    logic dx_pos;
    logic dy_pos;
  } dir_flags_t;

endpackage

// File: rtl/hefp_if.sv
// ----------------------------------------------------------------------------
// hefp_if
// Point pair and angle result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hefp_pts_if #(parameter int unsigned COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] eye_x;
  logic signed [COORD_BITS-1:0] eye_y;
  logic signed [COORD_BITS-1:0] eye_z;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic signed [COORD_BITS-1:0] target_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  output ready);
endinterface

interface hefp_ang_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] yaw_deg;
  logic signed [14:0] pitch_deg;

  modport source (output valid, yaw_deg, pitch_deg, input ready);
  modport sink   (input valid, yaw_deg, pitch_deg, output ready);
endinterface

// File: rtl/hefp_cordic_cell.sv
// ----------------------------------------------------------------------------
// hefp_cordic_cell
// One vectoring micro-rotation with its output register.
// ----------------------------------------------------------------------------
module hefp_cordic_cell
  import hefp_pkg::*;
#(
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}}, ATAN_TURNS[STEP]});

  logic signed [XW-1:0] x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_d;

  // rotate toward the x axis
  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule

// File: rtl/heading_elevation_from_points.sv
// ----------------------------------------------------------------------------
// heading_elevation_from_points
// Yaw and pitch of the vector from an eye point to a target point.
// ----------------------------------------------------------------------------
// pts_i takes one beat per point pair (eye and target, signed, 8 fraction
// bits); ang_o gives one beat per pair with yaw_deg (-90..270) and
// pitch_deg (-90..90), degrees with ANGLE_FRAC_BITS fraction bits.
// The datapath is two rows of CORDIC_STEPS vectoring cells: the first finds
// the heading and the horizontal length, the second the elevation.
// The pipeline's stages are one difference stage, the yaw cells, two stages
// for gain correction and yaw scaling, the pitch cells, and two stages for
// pitch scaling into the output register. Throughput is one beat per cycle
// while the receiver does not stall; a new pair is then taken every cycle.
// Each stage has a valid bit and loads when it is empty or its successor
// loads, so a stalled receiver holds the output beat while the upstream
// stages keep filling their bubbles; pts_i.ready drops only once every
// stage holds a beat. Reset clears all valid bits; no results are pending.
// ----------------------------------------------------------------------------
module heading_elevation_from_points
  import hefp_pkg::*;
#(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned ANGLE_FRAC_BITS = 7,
  parameter int unsigned CORDIC_STEPS    = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hefp_pts_if.sink   pts_i,
  hefp_ang_if.source ang_o
);

  localparam int unsigned N   = CORDIC_STEPS;
  localparam int unsigned NST = 2 * N + 5;
  localparam int unsigned SH  = 60 - COORD_BITS;
  localparam int unsigned FW  = $bits(dir_flags_t);
  localparam int unsigned SYW = XW + FW;
  localparam int unsigned SPW = YAW_W + FW;
  // degree scaling product and quotient widths
  localparam int unsigned KW  = 10 + ANGLE_FRAC_BITS;
  localparam int unsigned PW  = ZW + KW;
  localparam int unsigned QW  = PW - 32;

  localparam logic signed [KW-1:0] DEG_K    = KW'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [PW-1:0] RND      = PW'(64'h8000_0000);
  localparam logic signed [QW-1:0] DEG90    = QW'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [QW-1:0] DEG180   = QW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [QW-1:0] DEG270   = QW'(270 << ANGLE_FRAC_BITS);
  localparam logic signed [QW-1:0] DEG_N90  = -DEG90;
  localparam logic signed [QW-1:0] DEG_ZERO = '0;

  // stage valid bits and load enables
  logic [NST-1:0] v_q;
  logic [NST:0]   adv;

  assign adv[NST]    = ang_o.ready;
  assign pts_i.ready = adv[0];
  assign ang_o.valid = v_q[NST-1];

  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= pts_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // difference stage: scale, fold into the right half plane, flags
  logic signed [COORD_BITS:0] dx, dy, dz;
  logic signed [XW-1:0]       dxs, dys, dzs;
  logic signed [XW-1:0]       x0_d, y0_d, dz0_d;
  logic signed [ZW-1:0]       z0_d;
  dir_flags_t                 fl0_d;

  always_comb begin
    dx  = (COORD_BITS+1)'(pts_i.target_x) - (COORD_BITS+1)'(pts_i.eye_x);
    dy  = (COORD_BITS+1)'(pts_i.target_y) - (COORD_BITS+1)'(pts_i.eye_y);
    dz  = (COORD_BITS+1)'(pts_i.target_z) - (COORD_BITS+1)'(pts_i.eye_z);
    dxs = XW'(dx) <<< SH;
    dys = XW'(dy) <<< SH;
    dzs = XW'(dz) <<< SH;
    if (dx[COORD_BITS]) begin
      x0_d = -dxs;
      y0_d = -dys;
      z0_d = HALF_TURN;
    end else begin
      x0_d = dxs;
      y0_d = dys;
      z0_d = '0;
    end
    dz0_d         = dzs;
    fl0_d.dx_zero = (dx == '0);
    fl0_d.dy_zero = (dy == '0);
    fl0_d.dz_zero = (dz == '0);
    fl0_d.dz_neg  = dz[COORD_BITS];
    fl0_d.dx_pos  = !dx[COORD_BITS] && (dx != '0);
    fl0_d.dy_pos  = !dy[COORD_BITS] && (dy != '0);
  end

  logic signed [XW-1:0] yx [N+1];
  logic signed [XW-1:0] yy [N+1];
  logic signed [ZW-1:0] yz [N+1];
  logic [SYW-1:0]       ys [N+1];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      yx[0] <= x0_d;
      yy[0] <= y0_d;
      yz[0] <= z0_d;
      ys[0] <= {dz0_d, fl0_d};
    end
  end

  // heading cells
  for (genvar i = 0; i < N; i++) begin : g_yaw
    hefp_cordic_cell #(.STEP(i), .SIDE_W(SYW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv[i+1]),
      .x_i    (yx[i]),
      .y_i    (yy[i]),
      .z_i    (yz[i]),
      .side_i (ys[i]),
      .x_o    (yx[i+1]),
      .y_o    (yy[i+1]),
      .z_o    (yz[i+1]),
      .side_o (ys[i+1])
    );
  end

  // gain correction partial products and yaw scaling product
  logic [63:0]          mh_q, ml_q;
  logic signed [PW-1:0] pyaw_q;
  logic signed [XW-1:0] dz1_q;
  dir_flags_t           fl1_q;

  always_ff @(posedge clk_i) begin
    if (adv[N+1]) begin
      mh_q   <= 64'(yx[N][63:32]) * 64'(INV_GAIN);
      ml_q   <= 64'(yx[N][31:0]) * 64'(INV_GAIN);
      pyaw_q <= yz[N] * DEG_K;
      dz1_q  <= ys[N][SYW-1:FW];
      fl1_q  <= ys[N][FW-1:0];
    end
  end

  // yaw result and horizontal length
  logic signed [PW-1:0] pyaw_r;
  logic signed [QW-1:0] qyaw, yaw_sel;
  logic signed [XW-1:0] h_d;

  always_comb begin
    pyaw_r = pyaw_q + RND;
    qyaw   = pyaw_r[PW-1:32];
    if (fl1_q.dx_zero && fl1_q.dy_zero)  yaw_sel = DEG90;
    else if (fl1_q.dx_zero)              yaw_sel = fl1_q.dy_pos ? DEG90 : DEG_N90;
    else if (fl1_q.dy_zero)              yaw_sel = fl1_q.dx_pos ? DEG_ZERO : DEG180;
    else if (qyaw < DEG_N90)             yaw_sel = DEG_N90;
    else if (qyaw > DEG270)              yaw_sel = DEG270;
    else                                 yaw_sel = qyaw;
    h_d = $signed(mh_q + {32'd0, ml_q[63:32]});
  end

  logic signed [XW-1:0] px [N+1];
  logic signed [XW-1:0] py [N+1];
  logic signed [ZW-1:0] pz [N+1];
  logic [SPW-1:0]       ps [N+1];

  always_ff @(posedge clk_i) begin
    if (adv[N+2]) begin
      px[0] <= h_d;
      py[0] <= dz1_q;
      pz[0] <= '0;
      ps[0] <= {YAW_W'(yaw_sel), fl1_q};
    end
  end

  // elevation cells
  for (genvar i = 0; i < N; i++) begin : g_pitch
    hefp_cordic_cell #(.STEP(i), .SIDE_W(SPW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv[N+3+i]),
      .x_i    (px[i]),
      .y_i    (py[i]),
      .z_i    (pz[i]),
      .side_i (ps[i]),
      .x_o    (px[i+1]),
      .y_o    (py[i+1]),
      .z_o    (pz[i+1]),
      .side_o (ps[i+1])
    );
  end

  // pitch scaling product
  logic signed [PW-1:0] ppit_q;
  logic [SPW-1:0]       ps_q;

  always_ff @(posedge clk_i) begin
    if (adv[2*N+3]) begin
      ppit_q <= pz[N] * DEG_K;
      ps_q   <= ps[N];
    end
  end

  // pitch result
  logic signed [PW-1:0] ppit_r;
  logic signed [QW-1:0] qpit, pit_sel;
  dir_flags_t           fl2;

  always_comb begin
    fl2    = ps_q[FW-1:0];
    ppit_r = ppit_q + RND;
    qpit   = ppit_r[PW-1:32];
    if (fl2.dx_zero && fl2.dy_zero) pit_sel = fl2.dz_neg ? DEG_N90 : DEG90;
    else if (fl2.dz_zero)           pit_sel = DEG_ZERO;
    else if (qpit < DEG_N90)        pit_sel = DEG_N90;
    else if (qpit > DEG90)          pit_sel = DEG90;
    else                            pit_sel = qpit;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv[2*N+4]) begin
      ang_o.yaw_deg   <= ps_q[SPW-1:FW];
      ang_o.pitch_deg <= PITCH_W'(pit_sel);
    end
  end

endmodule
